// File: rtl/core/multichannel_fir_filter_defines.svh
// Assertion macros for the multichannel FIR filter checker.
// Needs nothing else; included by files that assert.
`ifndef MULTICHANNEL_FIR_FILTER_DEFINES_SVH
`define MULTICHANNEL_FIR_FILTER_DEFINES_SVH

// checked only while out of reset
`define MCFIR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define MCFIR_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/core/mcfir_pkg.sv
// Shared constants, command/status structs and helpers of the FIR filter.
// No dependencies.
package mcfir_pkg;

  localparam int TAPS      = 64;
  localparam int STREAMS   = 8;
  localparam int CHANNELS  = 16;
  localparam int COEF_SETS = 3;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int OUT_W    = 37;
  localparam int RATE_W   = 2;
  localparam int STREAM_W = 3;
  localparam int CHAN_W   = 4;
  localparam int CSET_W   = 2;
  localparam int CIDX_W   = 6;

  localparam int LINES     = STREAMS * CHANNELS;
  localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int TAP_W     = $clog2(TAPS);
  localparam int DLY_DEPTH = LINES * TAPS;
  localparam int DLY_AW    = $clog2(DLY_DEPTH);
  localparam int CF_DEPTH  = COEF_SETS * TAPS;
  localparam int CF_AW     = $clog2(CF_DEPTH);
  localparam int SET_W     = (COEF_SETS > 1) ? $clog2(COEF_SETS) : 1;

  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = (PROD_W + TAP_W > OUT_W) ? PROD_W + TAP_W : OUT_W + 1;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic              clr_we;
    logic [DLY_AW-1:0] clr_addr;
    logic              capture;
    logic              coef_we;
    logic              wr_sample;
    logic              tap_vld;
    logic [TAP_W-1:0]  tap;
    logic              tap_last;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic is_coef;
    logic filt_ok;
    logic mac_done;
    logic out_free;
  } sts_t;

  function automatic logic [DLY_AW-1:0] dly_addr(logic [LINE_W-1:0] line,
                                                 logic [TAP_W-1:0] off);
    return DLY_AW'(line) * DLY_AW'(TAPS) + DLY_AW'(off);
  endfunction

  function automatic logic [CF_AW-1:0] cf_addr(logic [SET_W-1:0] set,
                                               logic [TAP_W-1:0] idx);
    return CF_AW'(set) * CF_AW'(TAPS) + CF_AW'(idx);
  endfunction

endpackage

// File: rtl/core/mcfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mcfir_ctrl.sv
// Sequencer of the FIR filter: clearing pass, item accept, tap loop, result load.
// Depends on mcfir_pkg.
module mcfir_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mcfir_pkg::sts_t    sts_i,
  output mcfir_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PTR,
    S_RUN,
    S_DRAIN,
    S_OUT
  } state_e;

  state_e                           state_q, state_d;
  logic [mcfir_pkg::DLY_AW-1:0]     clr_q, clr_d;
  logic [mcfir_pkg::TAP_W-1:0]      tap_q, tap_d;
  logic                             stall_q;
  logic                             accept;
  logic                             clr_last;
  logic                             tap_last;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign clr_last = clr_q == mcfir_pkg::DLY_AW'(mcfir_pkg::DLY_DEPTH - 1);
  assign tap_last = tap_q == mcfir_pkg::TAP_W'(mcfir_pkg::TAPS - 1);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    tap_d   = tap_q;
    cmd_o   = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.tap      = tap_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_d        = clr_q + 1'b1;
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.capture = accept;
        cmd_o.coef_we = accept && sts_i.is_coef;
        if (accept && !sts_i.is_coef && sts_i.filt_ok) begin
          state_d = S_PTR;
        end
      end
      S_PTR: begin
        cmd_o.wr_sample = 1'b1;
        tap_d           = '0;
        state_d         = S_RUN;
      end
      S_RUN: begin
        cmd_o.tap_vld  = 1'b1;
        cmd_o.tap_last = tap_last;
        tap_d          = tap_q + 1'b1;
        if (tap_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.mac_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      tap_q   <= '0;
      stall_q <= 1'b1;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      tap_q   <= tap_d;
      stall_q <= state_d != S_IDLE;
    end
  end

  assign in_stall_o = stall_q;

endmodule

// File: rtl/core/mcfir_dp.sv
// Datapath of the FIR filter: delay-line, pointer and coefficient RAMs,
// multiply-accumulate pipeline, saturation and output register.
// Depends on mcfir_pkg and mcfir_ram.
module mcfir_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mcfir_pkg::cmd_t                      cmd_i,
  output mcfir_pkg::sts_t                      sts_o,
  input  logic [mcfir_pkg::RATE_W-1:0]         rate_i,
  input  logic                                 func_i,
  input  logic signed [mcfir_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [mcfir_pkg::STREAM_W-1:0]       stream_i,
  input  logic [mcfir_pkg::CHAN_W-1:0]         channel_i,
  input  logic [mcfir_pkg::CSET_W-1:0]         coef_set_i,
  input  logic [mcfir_pkg::CIDX_W-1:0]         coef_index_i,
  input  logic signed [mcfir_pkg::COEF_W-1:0]  coef_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mcfir_pkg::OUT_W-1:0]   filtered_o
);

  localparam int LW = mcfir_pkg::LINE_W;
  localparam int TW = mcfir_pkg::TAP_W;

  logic [LW-1:0]                         line_in, line_q;
  logic [mcfir_pkg::SAMPLE_W-1:0]        sample_q;
  logic [mcfir_pkg::SET_W-1:0]           set_in, set_q;
  logic [TW-1:0]                         ptr_rdata, head, head_q;
  logic [TW:0]                           off_sum;
  logic [TW-1:0]                         off;
  logic                                  coef_ok;

  logic                                  dly_we;
  logic [mcfir_pkg::DLY_AW-1:0]          dly_waddr, dly_raddr;
  logic [mcfir_pkg::SAMPLE_W-1:0]        dly_wdata, dly_rdata;
  logic                                  ptr_we;
  logic [LW-1:0]                         ptr_waddr;
  logic [TW-1:0]                         ptr_wdata;
  logic                                  cf_we;
  logic [mcfir_pkg::CF_AW-1:0]           cf_waddr, cf_raddr;
  logic [mcfir_pkg::COEF_W-1:0]          cf_rdata;

  logic                                  v1_q, last1_q, first1_q;
  logic                                  v2_q, last2_q, first2_q;
  logic signed [mcfir_pkg::PROD_W-1:0]   prod_q;
  logic signed [mcfir_pkg::ACC_W-1:0]    acc_q, sat;
  logic                                  done_q;
  logic                                  out_valid_q;
  logic signed [mcfir_pkg::OUT_W-1:0]    filtered_q;

  assign line_in = LW'(int'(stream_i) * mcfir_pkg::CHANNELS + int'(channel_i));
  assign set_in  = (int'(rate_i) >= mcfir_pkg::COEF_SETS) ?
                   mcfir_pkg::SET_W'(mcfir_pkg::COEF_SETS - 1) :
                   mcfir_pkg::SET_W'(rate_i);
  assign coef_ok = (int'(coef_set_i) < mcfir_pkg::COEF_SETS) &&
                   (int'(coef_index_i) < mcfir_pkg::TAPS);

  // newest sample goes one slot below the previous head
  assign head    = (ptr_rdata == '0) ? TW'(mcfir_pkg::TAPS - 1) : ptr_rdata - 1'b1;
  assign off_sum = {1'b0, head_q} + {1'b0, cmd_i.tap};
  assign off     = (int'(off_sum) >= mcfir_pkg::TAPS) ?
                   TW'(int'(off_sum) - mcfir_pkg::TAPS) : off_sum[TW-1:0];

  assign dly_we    = cmd_i.clr_we || cmd_i.wr_sample;
  assign dly_waddr = cmd_i.clr_we ? cmd_i.clr_addr : mcfir_pkg::dly_addr(line_q, head);
  assign dly_wdata = cmd_i.clr_we ? '0 : sample_q;
  assign dly_raddr = mcfir_pkg::dly_addr(line_q, off);

  assign ptr_we    = (cmd_i.clr_we && (int'(cmd_i.clr_addr) < mcfir_pkg::LINES)) ||
                     cmd_i.wr_sample;
  assign ptr_waddr = cmd_i.clr_we ? cmd_i.clr_addr[LW-1:0] : line_q;
  assign ptr_wdata = cmd_i.clr_we ? '0 : head;

  assign cf_we    = cmd_i.coef_we && coef_ok;
  assign cf_waddr = mcfir_pkg::cf_addr(mcfir_pkg::SET_W'(coef_set_i), TW'(coef_index_i));
  assign cf_raddr = mcfir_pkg::cf_addr(set_q, cmd_i.tap);

  mcfir_ram #(
    .WIDTH(mcfir_pkg::SAMPLE_W),
    .DEPTH(mcfir_pkg::DLY_DEPTH)
  ) u_dly_ram (
    .clk_i  (clk_i),
    .we_i   (dly_we),
    .waddr_i(dly_waddr),
    .wdata_i(dly_wdata),
    .raddr_i(dly_raddr),
    .rdata_o(dly_rdata)
  );

  mcfir_ram #(
    .WIDTH(TW),
    .DEPTH(mcfir_pkg::LINES)
  ) u_ptr_ram (
    .clk_i  (clk_i),
    .we_i   (ptr_we),
    .waddr_i(ptr_waddr),
    .wdata_i(ptr_wdata),
    .raddr_i(line_in),
    .rdata_o(ptr_rdata)
  );

  mcfir_ram #(
    .WIDTH(mcfir_pkg::COEF_W),
    .DEPTH(mcfir_pkg::CF_DEPTH)
  ) u_cf_ram (
    .clk_i  (clk_i),
    .we_i   (cf_we),
    .waddr_i(cf_waddr),
    .wdata_i(coef_value_i),
    .raddr_i(cf_raddr),
    .rdata_o(cf_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      line_q   <= line_in;
      sample_q <= sample_i;
      set_q    <= set_in;
    end
    if (cmd_i.wr_sample) begin
      head_q <= head;
    end
    last1_q  <= cmd_i.tap_last;
    first1_q <= cmd_i.tap == '0;
    last2_q  <= last1_q;
    first2_q <= first1_q;
    prod_q   <= $signed(dly_rdata) * $signed(cf_rdata);
    if (v2_q) begin
      acc_q <= first2_q ? mcfir_pkg::ACC_W'(prod_q) : acc_q + mcfir_pkg::ACC_W'(prod_q);
    end
    if (cmd_i.load_out) begin
      filtered_q <= sat[mcfir_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q   <= cmd_i.tap_vld;
      v2_q   <= v1_q;
      done_q <= v2_q && last2_q;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    priority if (acc_q > mcfir_pkg::SAT_MAX) begin
      sat = mcfir_pkg::SAT_MAX;
    end else if (acc_q < mcfir_pkg::SAT_MIN) begin
      sat = mcfir_pkg::SAT_MIN;
    end else begin
      sat = acc_q;
    end
  end

  assign sts_o.is_coef  = func_i;
  assign sts_o.filt_ok  = (int'(stream_i) < mcfir_pkg::STREAMS) &&
                          (int'(channel_i) < mcfir_pkg::CHANNELS);
  assign sts_o.mac_done = done_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

endmodule

// File: rtl/core/multichannel_fir_filter.sv
// Filter item on a valid stream and channel: pointer read, sample write, then 64 taps
// through one shared multiply-accumulate on the delay RAM read port, drain, result load;
// the next item can be taken in the cycle after the result loads, not before.
// Coefficient item: written on accept, no result. After reset a clearing pass
// zeroes every delay line; input stalls meanwhile, config writes still taken.
// Reset is asynchronous, active low. Depends on mcfir_pkg, mcfir_ctrl, mcfir_dp.
module multichannel_fir_filter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [1:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  func_i,
  input  logic signed [mcfir_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [mcfir_pkg::STREAM_W-1:0]        stream_i,
  input  logic [mcfir_pkg::CHAN_W-1:0]          channel_i,
  input  logic [mcfir_pkg::CSET_W-1:0]          coef_set_i,
  input  logic [mcfir_pkg::CIDX_W-1:0]          coef_index_i,
  input  logic signed [mcfir_pkg::COEF_W-1:0]   coef_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [mcfir_pkg::OUT_W-1:0]    filtered_o
);

  logic [mcfir_pkg::RATE_W-1:0] rate_q;
  mcfir_pkg::cmd_t              cmd;
  mcfir_pkg::sts_t              sts;
  logic                         unused_addr;

  // single register: every byte offset maps onto rate_select
  assign unused_addr = ^paddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= mcfir_pkg::RATE_W'(2);
    end else if (psel && penable && pwrite) begin
      rate_q <= pwdata[mcfir_pkg::RATE_W-1:0];
    end
  end

  assign prdata = {{(32 - mcfir_pkg::RATE_W){unused_addr & 1'b0}}, rate_q};
  assign pready = 1'b1;

  mcfir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mcfir_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rate_i      (rate_q),
    .func_i      (func_i),
    .sample_i    (sample_i),
    .stream_i    (stream_i),
    .channel_i   (channel_i),
    .coef_set_i  (coef_set_i),
    .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o)
  );

endmodule

// File: rtl/core/mcfir_checker.sv
// Port-level assertions of the FIR filter, bound to the top level.
// Depends on multichannel_fir_filter_defines.svh and mcfir_pkg.
`include "multichannel_fir_filter_defines.svh"

module mcfir_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_i,
  input logic                               func_i,
  input logic                               out_valid_i,
  input logic                               out_stall_i,
  input logic [mcfir_pkg::OUT_W-1:0]        filtered_i
);

  `MCFIR_ASSERT_ANY(a_no_out_in_reset, clk_i, !rst_ni |=> !out_valid_i, "result during reset")

  `MCFIR_ASSERT(a_clear_after_reset, clk_i, rst_ni, $rose(rst_ni) |-> in_stall_i, "input open during clear")

  `MCFIR_ASSERT(a_filter_busy, clk_i, rst_ni, (in_valid_i && !in_stall_i && !func_i) |=> in_stall_i, "filter item not held")

  `MCFIR_ASSERT(a_out_from_busy, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_stall_i), "result while idle")

  `MCFIR_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(filtered_i)), "stalled result changed")

endmodule

bind multichannel_fir_filter mcfir_checker u_mcfir_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .func_i     (func_i),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .filtered_i (filtered_o)
);

// File: verif/multichannel_fir_filter_test.sv
// Self-checking testbench for the multichannel FIR filter: coefficient loads, sample
// transfers on corner and random lines, active-set changes through the APB rate_select register.
// Depends on mcfir_pkg and the multichannel_fir_filter RTL.
module multichannel_fir_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mcfir_pkg::*;

  localparam logic       FUNC_FILTER      = 1'b0;
  localparam logic       FUNC_COEF        = 1'b1;
  localparam logic [1:0] RATE_SELECT_ADDR = 2'd0;
  localparam int         DRAIN_CYCLES     = 100;
  localparam int         WATCHDOG_LIMIT   = 40000;
  localparam longint     OUT_HI           = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint     OUT_LO           = -OUT_HI - 1;

  typedef struct {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    logic [STREAM_W-1:0]        stream;
    logic [CHAN_W-1:0]          channel;
    logic [CSET_W-1:0]          coef_set;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } fir_item_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [1:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       func_i = FUNC_FILTER;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic [STREAM_W-1:0]        stream_i = '0;
  logic [CHAN_W-1:0]          channel_i = '0;
  logic [CSET_W-1:0]          coef_set_i = '0;
  logic [CIDX_W-1:0]          coef_index_i = '0;
  logic signed [COEF_W-1:0]   coef_value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [OUT_W-1:0]    filtered_o;

  fir_item_t               item_q[$];
  fir_item_t               cur_item;
  logic signed [OUT_W-1:0] filtered_q[$];
  logic signed [OUT_W-1:0] want_filtered;
  logic signed [SAMPLE_W-1:0] line_mem [LINES][TAPS];
  logic signed [COEF_W-1:0]   coef_mem [COEF_SETS][TAPS];
  logic [RATE_W-1:0]       rate_sel = 2'd2;
  int                      src_idle_pct = 0;
  int                      dst_idle_pct = 0;
  int                      err_cnt = 0;
  int                      quiet_cycles = 0;

  multichannel_fir_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .sample_i     (sample_i),
    .stream_i     (stream_i),
    .channel_i    (channel_i),
    .coef_set_i   (coef_set_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .filtered_o   (filtered_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shift the sample into its line and form the saturated tap sum, or store a coefficient
  function automatic void shift_and_filter(fir_item_t it);
    int     ln;
    int     set;
    longint acc;
    if (it.func == FUNC_COEF) begin
      if (it.coef_set < COEF_SETS && it.coef_index < TAPS)
        coef_mem[it.coef_set][it.coef_index] = it.coef_value;
      return;
    end
    if (it.stream >= STREAMS || it.channel >= CHANNELS)
      return;
    ln  = it.stream * CHANNELS + it.channel;
    set = (rate_sel >= COEF_SETS) ? COEF_SETS - 1 : rate_sel;
    for (int i = TAPS - 1; i > 0; i--)
      line_mem[ln][i] = line_mem[ln][i-1];
    line_mem[ln][0] = it.sample;
    acc = 0;
    for (int i = 0; i < TAPS; i++)
      acc += longint'(line_mem[ln][i]) * longint'(coef_mem[set][i]);
    if (acc > OUT_HI)
      acc = OUT_HI;
    if (acc < OUT_LO)
      acc = OUT_LO;
    filtered_q.push_back(OUT_W'(acc));
  endfunction

  function automatic logic signed [15:0] rand_word();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0)
      return 16'sh8000;
    if (roll == 1)
      return 16'sh7fff;
    return 16'($urandom);
  endfunction

  function automatic void queue_filter(int st, int ch, logic signed [15:0] s);
    fir_item_t it;
    it.func       = FUNC_FILTER;
    it.sample     = s;
    it.stream     = STREAM_W'(st);
    it.channel    = CHAN_W'(ch);
    it.coef_set   = CSET_W'($urandom);
    it.coef_index = CIDX_W'($urandom);
    it.coef_value = 16'($urandom);
    item_q.push_back(it);
  endfunction

  function automatic void queue_coef(int set, int idx, logic signed [15:0] v);
    fir_item_t it;
    it.func       = FUNC_COEF;
    it.sample     = 16'($urandom);
    it.stream     = STREAM_W'($urandom);
    it.channel    = CHAN_W'($urandom);
    it.coef_set   = CSET_W'(set);
    it.coef_index = CIDX_W'(idx);
    it.coef_value = v;
    item_q.push_back(it);
  endfunction

  // most samples land on the four corner lines so their delay lines fill up
  function automatic void queue_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 20)
        queue_coef($urandom_range(3), $urandom_range(TAPS - 1), rand_word());
      else if ($urandom_range(9) < 7)
        queue_filter($urandom_range(1) * (STREAMS - 1), $urandom_range(1) * (CHANNELS - 1),
                     rand_word());
      else
        queue_filter($urandom_range(STREAMS - 1), $urandom_range(CHANNELS - 1), rand_word());
    end
  endfunction

  task automatic write_rate(logic [RATE_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RATE_SELECT_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready)
      @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rate_sel = v;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (item_q.size() != 0 || in_valid_i || filtered_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic flag_error(string what, logic signed [OUT_W-1:0] want,
                            logic signed [OUT_W-1:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch: %s filtered expected %0d actual %0d", what, want, got);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        shift_and_filter(cur_item);
      if (!in_valid_i || !in_stall_o) begin
        if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_item = item_q.pop_front();
          in_valid_i   <= 1'b1;
          func_i       <= cur_item.func;
          sample_i     <= cur_item.sample;
          stream_i     <= cur_item.stream;
          channel_i    <= cur_item.channel;
          coef_set_i   <= cur_item.coef_set;
          coef_index_i <= cur_item.coef_index;
          coef_value_i <= cur_item.coef_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          flag_error("unexpected transfer,", 'x, filtered_o);
        end else begin
          want_filtered = filtered_q.pop_front();
          if (filtered_o !== want_filtered)
            flag_error("wrong value,", want_filtered, filtered_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[multichannel_fir_filter] ERROR");
        $finish;
      end
    end
  end

  initial begin
    foreach (line_mem[l, t])
      line_mem[l][t] = '0;
    foreach (coef_mem[s, t])
      coef_mem[s][t] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 13;
    dst_idle_pct = 73;
    write_rate(2'd3);  // out of range, selects the last set
    for (int i = 0; i < TAPS; i++) begin
      queue_coef(2, i, 16'sh8000);
      queue_coef(0, i, rand_word());
      queue_coef(1, i, rand_word());
    end
    queue_coef(3, 5, 16'sh1234);  // no such set, dropped
    for (int i = 0; i < TAPS; i++)
      queue_filter(STREAMS - 1, CHANNELS - 1, 16'sh8000);  // last one saturates
    queue_filter(0, 0, 16'sh7fff);
    queue_filter(0, 0, 16'sh8000);
    queue_filter(0, 0, 16'sh0000);
    drain();

    write_rate(2'd0);
    queue_random(150);
    drain();

    src_idle_pct = 73;
    dst_idle_pct = 13;
    write_rate(2'd1);
    queue_random(145);
    drain();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    write_rate(2'd2);
    queue_random(145);
    drain();

    if (err_cnt == 0 && filtered_q.size() == 0)
      $display("[multichannel_fir_filter] OK");
    else
      $display("[multichannel_fir_filter] ERROR");
    $finish;
  end

endmodule
